### hdl/drpi_pkg.sv
// Shared types, constants and helpers for the dead-reckoning pose integrator.
// No dependencies; imported by every module of the block.
package drpi_pkg;

  localparam int TURN_W      = 8;
  localparam int GAIN_W      = 16;
  localparam int POS_W       = 32;
  localparam int HEAD_W      = 16;
  localparam int PROD_W      = TURN_W + GAIN_W + 1;
  localparam int SUM_W       = POS_W + 2;
  localparam int DX_W        = 28;
  localparam int CORDIC_STEPS = 28;
  localparam int STEP_W      = 5;
  localparam int GAIN_Q30    = 652032874;

  localparam logic [HEAD_W-1:0] HEAD_RESET = 16'd16384;
  localparam logic [GAIN_W-1:0] AGAIN_RESET = 16'd256;
  localparam logic [GAIN_W-1:0] LGAIN_RESET = 16'd655;

  localparam logic [31:0] ATAN_TAB [CORDIC_STEPS] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
    32'h00000014, 32'h0000000A, 32'h00000005
  };

  typedef enum logic [0:0] {
    REG_ANGULAR_GAIN = 1'b0,
    REG_LINEAR_GAIN  = 1'b1
  } reg_index_t;

  typedef enum logic [0:0] {
    OP_COMMAND = 1'b0,
    OP_TICK    = 1'b1
  } opcode_t;

  typedef struct packed {
    logic              is_tick;
    logic [TURN_W-1:0] turn;
    logic [TURN_W-1:0] speed;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } queue_head_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_HEAD,
    BK_ROT,
    BK_MULX,
    BK_MULY,
    BK_ADDY,
    BK_OUT
  } back_state_t;

  function automatic logic [POS_W-1:0] sat_pos(input logic [SUM_W-1:0] s);
    logic [POS_W-1:0] r;
    if (s[SUM_W-1:POS_W-1] == '0 || s[SUM_W-1:POS_W-1] == '1) begin
      r = s[POS_W-1:0];
    end else if (s[SUM_W-1]) begin
      r = {1'b1, {(POS_W-1){1'b0}}};
    end else begin
      r = {1'b0, {(POS_W-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

### hdl/dead_reckoning_pose_integrator.sv
// Top level of the dead-reckoning pose integrator: gain registers, front end
// queue and back end. Depends on drpi_pkg, drpi_front and drpi_back.
//
//   channel | direction | handshake        | beat
//   in_     | input     | in_valid/stall   | opcode, turn_value, speed_value
//   out_    | output    | out_valid/stall  | position_x, position_y, heading
//   cfg_    | input     | cfg_valid/ready  | index, data (gain registers)
//
// In the back end a tick after the first command runs the heading update, the
// iterative CORDIC, the x and y multiplies with saturating adds and the output
// load. A command is taken straight from idle; an early tick goes to output.
// rst_n is synchronous; the pose returns to origin facing 90 degrees.
// A two-beat queue lets the input side run on while the output stalls.
module dead_reckoning_pose_integrator #(
  parameter int TRIG_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        in_opcode,
  input  logic [drpi_pkg::TURN_W-1:0] in_turn_value,
  input  logic [drpi_pkg::TURN_W-1:0] in_speed_value,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [drpi_pkg::POS_W-1:0]  out_position_x,
  output logic [drpi_pkg::POS_W-1:0]  out_position_y,
  output logic [drpi_pkg::HEAD_W-1:0] out_heading,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic                        cfg_index,
  input  logic [drpi_pkg::GAIN_W-1:0] cfg_data
);
  import drpi_pkg::*;

  logic [GAIN_W-1:0] angular_gain_r;
  logic [GAIN_W-1:0] linear_gain_r;
  queue_head_t       head;
  logic              pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      angular_gain_r <= AGAIN_RESET;
      linear_gain_r  <= LGAIN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (reg_index_t'(cfg_index))
        REG_ANGULAR_GAIN: angular_gain_r <= cfg_data;
        REG_LINEAR_GAIN:  linear_gain_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  drpi_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_opcode      (in_opcode),
    .in_turn_value  (in_turn_value),
    .in_speed_value (in_speed_value),
    .head_o         (head),
    .pop_i          (pop)
  );

  drpi_back #(.TRIG_BITS(TRIG_BITS)) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head_i         (head),
    .pop_o          (pop),
    .angular_gain_i (angular_gain_r),
    .linear_gain_i  (linear_gain_r),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_position_x (out_position_x),
    .out_position_y (out_position_y),
    .out_heading    (out_heading)
  );

endmodule

### hdl/drpi_front.sv
// Front end: accepts input beats, classifies them as command or tick and
// holds them in a two-entry queue for the back end. Uses drpi_pkg.
module drpi_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        in_opcode,
  input  logic [drpi_pkg::TURN_W-1:0] in_turn_value,
  input  logic [drpi_pkg::TURN_W-1:0] in_speed_value,
  output drpi_pkg::queue_head_t       head_o,
  input  logic                        pop_i
);
  import drpi_pkg::*;

  item_t      mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       push;
  logic       pop;
  item_t      new_item;

  assign in_stall = (count_r == 2'd2);
  assign push     = in_valid && !in_stall;
  assign pop      = pop_i && (count_r != 2'd0);

  always_comb begin
    new_item.is_tick = (opcode_t'(in_opcode) == OP_TICK);
    new_item.turn    = in_turn_value;
    new_item.speed   = in_speed_value;
  end

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= new_item;
    end
  end

  assign head_o.valid = (count_r != 2'd0);
  assign head_o.item  = mem_r[rd_ptr_r];

endmodule

### hdl/drpi_cordic.sv
// Iterative rotation CORDIC: one micro-rotation per cycle over the
// arctangent table of drpi_pkg, quadrant fold on entry.
module drpi_cordic #(
  parameter int TRIG_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start_i,
  input  logic [drpi_pkg::HEAD_W-1:0]   angle_i,
  output logic                          done_o,
  output logic signed [TRIG_BITS+2:0]   cos_o,
  output logic signed [TRIG_BITS+2:0]   sin_o
);
  import drpi_pkg::*;

  localparam int XW = TRIG_BITS + 3;
  localparam int ZW = 34;
  localparam logic [63:0] X0_WIDE =
    (64'(GAIN_Q30) + (64'd1 << (29 - TRIG_BITS))) >> (30 - TRIG_BITS);
  localparam logic signed [XW-1:0] X0 = XW'(X0_WIDE);

  logic signed [XW-1:0] x_r, y_r;
  logic signed [ZW-1:0] z_r;
  logic [STEP_W-1:0]    cnt_r;
  logic                 busy_r;
  logic                 done_r;
  logic                 flip_r;
  logic signed [XW-1:0] xs, ys;
  logic signed [ZW-1:0] at;
  logic                 last;

  assign xs   = x_r >>> cnt_r;
  assign ys   = y_r >>> cnt_r;
  assign at   = $signed({2'b00, ATAN_TAB[cnt_r]});
  assign last = (cnt_r == STEP_W'(CORDIC_STEPS - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start_i) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (last) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start_i) begin
      flip_r <= angle_i[15] ^ angle_i[14];
      x_r    <= X0;
      y_r    <= '0;
      z_r    <= $signed({{3{angle_i[14]}}, angle_i[14:0], 16'h0000});
    end else if (busy_r) begin
      if (!z_r[ZW-1]) begin
        x_r <= x_r - ys;
        y_r <= y_r + xs;
        z_r <= z_r - at;
      end else begin
        x_r <= x_r + ys;
        y_r <= y_r - xs;
        z_r <= z_r + at;
      end
    end
  end

  assign done_o = done_r;
  assign cos_o  = flip_r ? -x_r : x_r;
  assign sin_o  = flip_r ? -y_r : y_r;

endmodule

### hdl/drpi_back.sv
// Back end: executes queued commands and ticks, keeps the pose and drives
// the output register. Uses drpi_pkg and drpi_cordic.
module drpi_back #(
  parameter int TRIG_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  drpi_pkg::queue_head_t       head_i,
  output logic                        pop_o,
  input  logic [drpi_pkg::GAIN_W-1:0] angular_gain_i,
  input  logic [drpi_pkg::GAIN_W-1:0] linear_gain_i,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [drpi_pkg::POS_W-1:0]  out_position_x,
  output logic [drpi_pkg::POS_W-1:0]  out_position_y,
  output logic [drpi_pkg::HEAD_W-1:0] out_heading
);
  import drpi_pkg::*;

  localparam int XW = TRIG_BITS + 3;
  localparam int PW = XW + PROD_W;
  localparam logic signed [PW-1:0] RND = PW'(1) << (TRIG_BITS - 1);

  back_state_t state_r, state_nxt;

  logic [TURN_W-1:0]        turn_r, speed_r;
  logic                     seen_r;
  logic [POS_W-1:0]         pos_x_r, pos_y_r;
  logic [HEAD_W-1:0]        heading_r;
  logic signed [PROD_W-1:0] p_r, d_r;
  logic signed [PW-1:0]     prod_r;
  logic                     out_valid_r;
  logic [POS_W-1:0]         out_x_r, out_y_r;
  logic [HEAD_W-1:0]        out_h_r;

  logic                     cord_start;
  logic                     cord_done;
  logic signed [XW-1:0]     cos_v, sin_v;
  logic signed [PROD_W-1:0] p_rnd;
  logic signed [16:0]       step;
  logic signed [16:0]       step_n;
  logic [HEAD_W-1:0]        heading_new;
  logic signed [PW-1:0]     shifted;
  logic signed [DX_W-1:0]   delta;
  logic [SUM_W-1:0]         sum_x, sum_y;
  logic                     out_free;
  logic                     load_out;
  logic                     take_cmd;

  drpi_cordic #(.TRIG_BITS(TRIG_BITS)) u_cordic (
    .clk     (clk),
    .rst_n   (rst_n),
    .start_i (cord_start),
    .angle_i (heading_new),
    .done_o  (cord_done),
    .cos_o   (cos_v),
    .sin_o   (sin_v)
  );

  assign p_rnd       = p_r + PROD_W'(128);
  assign step        = 17'(p_rnd >>> 8);
  assign step_n      = ($signed(pos_x_r) <= 0) ? -step : step;
  assign heading_new = heading_r + step_n[HEAD_W-1:0];
  assign shifted     = (prod_r + RND) >>> TRIG_BITS;
  assign delta       = shifted[DX_W-1:0];
  assign sum_x       = {{2{pos_x_r[POS_W-1]}}, pos_x_r}
                     + {{(SUM_W-DX_W){delta[DX_W-1]}}, delta};
  assign sum_y       = {{2{pos_y_r[POS_W-1]}}, pos_y_r}
                     + {{(SUM_W-DX_W){delta[DX_W-1]}}, delta};
  assign out_free    = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt  = state_r;
    pop_o      = 1'b0;
    cord_start = 1'b0;
    load_out   = 1'b0;
    take_cmd   = 1'b0;
    case (state_r)
      BK_IDLE: begin
        if (head_i.valid) begin
          if (!head_i.item.is_tick) begin
            take_cmd = 1'b1;
            pop_o    = 1'b1;
          end else if (seen_r) begin
            state_nxt = BK_HEAD;
          end else begin
            state_nxt = BK_OUT;
          end
        end
      end
      BK_HEAD: begin
        cord_start = 1'b1;
        state_nxt  = BK_ROT;
      end
      BK_ROT: begin
        if (cord_done) begin
          state_nxt = BK_MULX;
        end
      end
      BK_MULX: state_nxt = BK_MULY;
      BK_MULY: state_nxt = BK_ADDY;
      BK_ADDY: state_nxt = BK_OUT;
      BK_OUT: begin
        if (out_free) begin
          load_out  = 1'b1;
          pop_o     = 1'b1;
          state_nxt = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      seen_r      <= 1'b0;
      turn_r      <= '0;
      speed_r     <= '0;
      pos_x_r     <= '0;
      pos_y_r     <= '0;
      heading_r   <= HEAD_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (take_cmd) begin
        seen_r  <= 1'b1;
        turn_r  <= head_i.item.turn;
        speed_r <= head_i.item.speed;
      end
      if (state_r == BK_HEAD) begin
        heading_r <= heading_new;
      end
      if (state_r == BK_MULY) begin
        pos_x_r <= sat_pos(sum_x);
      end
      if (state_r == BK_ADDY) begin
        pos_y_r <= sat_pos(sum_y);
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == BK_IDLE) begin
      p_r <= $signed(turn_r) * $signed({1'b0, angular_gain_i});
      d_r <= $signed(speed_r) * $signed({1'b0, linear_gain_i});
    end
    if (state_r == BK_MULX) begin
      prod_r <= cos_v * d_r;
    end else if (state_r == BK_MULY) begin
      prod_r <= sin_v * d_r;
    end
    if (load_out) begin
      out_x_r <= pos_x_r;
      out_y_r <= pos_y_r;
      out_h_r <= heading_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_position_x = out_x_r;
  assign out_position_y = out_y_r;
  assign out_heading    = out_h_r;

endmodule

### test/tb_top.sv
// Self-checking testbench for dead_reckoning_pose_integrator: drives command and tick beats,
// predicts every pose and checks each result beat field by field.
// Depends on drpi_pkg and the dead_reckoning_pose_integrator RTL.
module tb_top;
  import drpi_pkg::*;

  localparam int TRIG_BITS = 16;
  localparam int SETTLE_CYCLES = 64;
  localparam int HOLD_CYCLES = 400;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int MAX_PRINTS = 100;
  localparam longint ROUND_HALF = longint'(1) << (TRIG_BITS - 1);
  localparam longint POS_MAX_L = 64'sd2147483647;
  localparam longint POS_MIN_L = -64'sd2147483648;

  typedef struct {
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [15:0] heading;
  } pose_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_opcode = 1'b0;
  logic [7:0] in_turn_value = '0;
  logic [7:0] in_speed_value = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [31:0] out_position_x;
  logic [31:0] out_position_y;
  logic [15:0] out_heading;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_index = 1'b0;
  logic [15:0] cfg_data = '0;

  // predicted block state
  logic [15:0] angular_gain_q = AGAIN_RESET;
  logic [15:0] linear_gain_q = LGAIN_RESET;
  logic signed [7:0] cmd_turn = '0;
  logic signed [7:0] cmd_speed = '0;
  logic cmd_seen = 1'b0;
  logic signed [31:0] pose_x = '0;
  logic signed [31:0] pose_y = '0;
  logic [15:0] pose_heading = HEAD_RESET;

  pose_t pending_poses[$];
  int mismatch_count = 0;
  int in_idle_pct = 0;
  int out_idle_pct = 0;
  int hold_cycles = 0;
  int quiet_cycles = 0;

  dead_reckoning_pose_integrator #(.TRIG_BITS(TRIG_BITS)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_opcode(in_opcode),
    .in_turn_value(in_turn_value), .in_speed_value(in_speed_value),
    .out_valid(out_valid), .out_stall(out_stall), .out_position_x(out_position_x),
    .out_position_y(out_position_y), .out_heading(out_heading),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  function automatic logic [7:0] rand_byte();
    return 8'($urandom_range(255));
  endfunction

  function automatic longint heading_step(input logic signed [7:0] turn,
                                          input logic [15:0] gain);
    return (longint'(turn) * longint'(gain) + 128) >>> 8;
  endfunction

  function automatic logic signed [31:0] clamp_q16(input longint v);
    if (v > POS_MAX_L) return 32'sh7FFFFFFF;
    if (v < POS_MIN_L) return 32'sh80000000;
    return v[31:0];
  endfunction

  // fold into +/-90 degrees, then rotation-mode CORDIC
  function automatic void sincos_of_heading(input logic [15:0] hdg, output longint cosv,
                                            output longint sinv);
    logic [31:0] ang;
    logic turned;
    longint xr, yr, zr, xs, ys;
    int i;
    ang = {hdg, 16'h0000};
    turned = (ang[31:30] == 2'b01) || (ang[31:30] == 2'b10);
    if (turned) ang[31] = ~ang[31];
    zr = longint'(signed'(ang));
    xr = (longint'(GAIN_Q30) + (longint'(1) << (29 - TRIG_BITS))) >>> (30 - TRIG_BITS);
    yr = 0;
    for (i = 0; i < CORDIC_STEPS; i++) begin
      xs = xr >>> i;
      ys = yr >>> i;
      if (zr >= 0) begin
        xr = xr - ys;
        yr = yr + xs;
        zr = zr - longint'(ATAN_TAB[i]);
      end else begin
        xr = xr + ys;
        yr = yr - xs;
        zr = zr + longint'(ATAN_TAB[i]);
      end
    end
    cosv = turned ? -xr : xr;
    sinv = turned ? -yr : yr;
  endfunction

  function automatic void advance_pose(input opcode_t op, input logic signed [7:0] turn,
                                       input logic signed [7:0] speed);
    longint stepv, cosv, sinv, travel;
    pose_t p;
    if (op == OP_COMMAND) begin
      cmd_turn = turn;
      cmd_speed = speed;
      cmd_seen = 1'b1;
      return;
    end
    if (cmd_seen) begin
      stepv = heading_step(cmd_turn, angular_gain_q);
      if (pose_x <= 0) stepv = -stepv;
      pose_heading = pose_heading + stepv[15:0];
      sincos_of_heading(pose_heading, cosv, sinv);
      travel = longint'(cmd_speed) * longint'(linear_gain_q);
      pose_x = clamp_q16(longint'(pose_x) + ((cosv * travel + ROUND_HALF) >>> TRIG_BITS));
      pose_y = clamp_q16(longint'(pose_y) + ((sinv * travel + ROUND_HALF) >>> TRIG_BITS));
    end
    p.pos_x = pose_x;
    p.pos_y = pose_y;
    p.heading = pose_heading;
    pending_poses = {pending_poses, p};
  endfunction

  function automatic logic [15:0] pick_gain();
    case ($urandom_range(3))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom_range(65535));
    endcase
  endfunction

  task automatic report_mismatch(input string msg);
    if (mismatch_count < MAX_PRINTS) $display("%0t: mismatch: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want_v);
    if (got !== want_v)
      report_mismatch($sformatf("%s got %h, want %h", name, got, want_v));
  endtask

  task automatic drive_item(input opcode_t op, input logic [7:0] turn,
                            input logic [7:0] speed);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_opcode <= op;
    in_turn_value <= turn;
    in_speed_value <= speed;
    do @(posedge clk); while (in_stall);
    advance_pose(op, turn, speed);
  endtask

  // commands leave nothing to wait on, so let the back end settle too
  task automatic quiesce();
    in_valid <= 1'b0;
    while (pending_poses.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input reg_index_t idx, input logic [15:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_ANGULAR_GAIN) angular_gain_q = value;
    else linear_gain_q = value;
    @(posedge clk);
  endtask

  // rotate the predicted heading onto target with zero speed
  task automatic steer_to(input logic [15:0] target);
    logic signed [15:0] delta;
    logic signed [7:0] turn;
    longint want, mag;
    int k, j, g0, g;
    for (k = 0; k < 4 && pose_heading != target; k++) begin
      delta = target - pose_heading;
      want = (pose_x <= 0) ? -longint'(delta) : longint'(delta);
      if (want > 32000) want = 32000;
      else if (want < -32000) want = -32000;
      turn = (want < 0) ? -8'sd127 : 8'sd127;
      mag = (want < 0) ? -want : want;
      g0 = int'(mag * 256 / 127);
      g = g0;
      for (j = g0 - 3; j <= g0 + 3; j++)
        if (j >= 0 && j <= 65535 && heading_step(turn, j[15:0]) == want) g = j;
      quiesce();
      write_reg(REG_ANGULAR_GAIN, g[15:0]);
      drive_item(OP_COMMAND, turn, 8'd0);
      drive_item(OP_TICK, rand_byte(), rand_byte());
    end
  endtask

  task automatic test_directed();
    drive_item(OP_TICK, 8'h00, 8'h00);
    drive_item(OP_TICK, 8'hFF, 8'h80);
    drive_item(OP_COMMAND, 8'sd0, 8'sd0);
    drive_item(OP_TICK, 8'h00, 8'h00);
    drive_item(OP_COMMAND, 8'sd127, 8'sd127);
    repeat (2) drive_item(OP_TICK, 8'h7F, 8'h7F);
    drive_item(OP_COMMAND, -8'sd128, -8'sd128);
    repeat (2) drive_item(OP_TICK, 8'h80, 8'h80);
    drive_item(OP_COMMAND, 8'sd1, 8'sd1);
    drive_item(OP_COMMAND, -8'sd1, -8'sd1);
    drive_item(OP_TICK, 8'h00, 8'h00);
    drive_item(OP_COMMAND, 8'sd127, -8'sd128);
    drive_item(OP_TICK, 8'h00, 8'h00);
    drive_item(OP_COMMAND, -8'sd128, 8'sd127);
    drive_item(OP_TICK, 8'h00, 8'h00);
    // full gains: large heading steps wrap the angle
    quiesce();
    write_reg(REG_ANGULAR_GAIN, 16'hFFFF);
    write_reg(REG_LINEAR_GAIN, 16'hFFFF);
    drive_item(OP_COMMAND, 8'sd127, 8'sd127);
    repeat (2) drive_item(OP_TICK, 8'h00, 8'h00);
    drive_item(OP_COMMAND, -8'sd128, -8'sd128);
    drive_item(OP_TICK, 8'h00, 8'h00);
    quiesce();
    write_reg(REG_ANGULAR_GAIN, 16'h0000);
    write_reg(REG_LINEAR_GAIN, 16'h0000);
    drive_item(OP_COMMAND, -8'sd128, 8'sd127);
    drive_item(OP_TICK, 8'h00, 8'h00);
  endtask

  task automatic test_random(input int n_items, input int in_pct, input int out_pct);
    int seg, sent, k, ticks;
    in_idle_pct = in_pct;
    out_idle_pct = out_pct;
    for (seg = 0; seg < 3; seg++) begin
      quiesce();
      write_reg(REG_ANGULAR_GAIN, pick_gain());
      write_reg(REG_LINEAR_GAIN, pick_gain());
      sent = 0;
      while (sent < n_items / 3) begin
        k = $urandom_range(9);
        if (k < 8) begin
          drive_item(OP_COMMAND, rand_byte(), rand_byte());
          ticks = $urandom_range(8, 1);
          repeat (ticks) drive_item(OP_TICK, rand_byte(), rand_byte());
          sent += ticks + 1;
        end else if (k == 8) begin
          drive_item(opcode_t'($urandom_range(1)), rand_byte(), rand_byte());
          sent++;
        end else begin
          repeat (2) drive_item(OP_COMMAND, rand_byte(), rand_byte());
          sent += 2;
        end
      end
    end
  endtask

  // output held off while ticks keep coming; the queue fills and in_stall rises
  task automatic test_backpressure();
    int n;
    quiesce();
    in_idle_pct = 0;
    out_idle_pct = 0;
    hold_cycles <= HOLD_CYCLES;
    drive_item(OP_COMMAND, rand_byte(), rand_byte());
    for (n = 0; n < 24; n++) drive_item(OP_TICK, rand_byte(), rand_byte());
  endtask

  // run x into its upper limit, then y into its lower limit
  task automatic test_saturation();
    int n;
    quiesce();
    in_idle_pct = 10;
    out_idle_pct = 10;
    write_reg(REG_LINEAR_GAIN, 16'hFFFF);
    steer_to(16'h0000);
    drive_item(OP_COMMAND, 8'sd0, 8'sd127);
    for (n = 0; n < 700 && pose_x != 32'sh7FFFFFFF; n++)
      drive_item(OP_TICK, rand_byte(), rand_byte());
    repeat (4) drive_item(OP_TICK, rand_byte(), rand_byte());
    steer_to(16'h4000);
    drive_item(OP_COMMAND, 8'sd0, -8'sd128);
    for (n = 0; n < 700 && pose_y != 32'sh80000000; n++)
      drive_item(OP_TICK, rand_byte(), rand_byte());
    repeat (4) drive_item(OP_TICK, rand_byte(), rand_byte());
  endtask

  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      out_stall <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_stall <= ($urandom_range(99) < out_idle_pct);
    end
  end

  always @(posedge clk) begin : check_beat
    pose_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_poses.size() == 0) begin
        report_mismatch("result beat with no pose pending");
      end else begin
        want = pending_poses.pop_front();
        check_field("position_x", out_position_x, want.pos_x);
        check_field("position_y", out_position_y, want.pos_y);
        check_field("heading", {16'h0000, out_heading}, {16'h0000, want.heading});
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    wait (quiet_cycles >= WATCHDOG_LIMIT);
    $display("tb_top: FAIL");
    $finish;
  end

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(260, 28, 69);
    test_random(260, 69, 28);
    test_random(260, 0, 0);
    test_backpressure();
    test_saturation();
    quiesce();
    if (pending_poses.size() != 0) report_mismatch("poses still pending at end");
    if (mismatch_count == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
